// ===== src/gf2m_pkg.sv =====
// gf2m_pkg: shared types and constants of the gf(2^m) arithmetic unit
`default_nettype none

package gf2m_pkg;

  localparam int unsigned GF_PORT_W  = 64;
  localparam int unsigned GF_EXP_W   = 31;
  localparam int unsigned GF_DIGIT_W = 8;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_POW = 2'd2
  } kind_e;

  typedef struct packed {
    logic load;
    logic round_start;
    logic step;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/gf2m_dp.sv =====
// gf2m_dp: operand registers, polynomial register and two digit-serial multipliers
`default_nettype none

module gf2m_dp
  import gf2m_pkg::*;
#(
  parameter int unsigned DEGREE = 63
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [GF_PORT_W-1:0] cfg_wdata_i,
  input  wire logic [1:0]           kind_i,
  input  wire logic [GF_PORT_W-1:0] operand_a_i,
  input  wire logic [GF_PORT_W-1:0] operand_b_i,
  input  wire logic [GF_EXP_W-1:0]  exponent_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output logic [GF_PORT_W-1:0]      value_o
);

  localparam int unsigned NDIG = (DEGREE + GF_DIGIT_W - 1) / GF_DIGIT_W;
  localparam int unsigned BW   = NDIG * GF_DIGIT_W;

  logic [DEGREE-1:0]   poly_q;
  logic [DEGREE-1:0]   res_q, res_d;
  logic [DEGREE-1:0]   base_q, base_d;
  logic [GF_EXP_W-1:0] exp_q, exp_d;
  logic [DEGREE-1:0]   acc0_q, acc0_d;
  logic [DEGREE-1:0]   acc1_q, acc1_d;
  logic [BW-1:0]       sr0_q, sr0_d;
  logic [BW-1:0]       sr1_q, sr1_d;
  logic [DEGREE-1:0]   value_q;
  logic [DEGREE-1:0]   a_m, b_m;

  // one digit of a msb-first carry-less multiply with reduction
  function automatic logic [DEGREE-1:0] mul_step(
    input logic [DEGREE-1:0]     acc,
    input logic [DEGREE-1:0]     mcand,
    input logic [GF_DIGIT_W-1:0] digit,
    input logic [DEGREE-1:0]     poly
  );
    logic [DEGREE-1:0] r;
    logic              top;
    r = acc;
    for (int j = GF_DIGIT_W - 1; j >= 0; j--) begin
      top = r[DEGREE-1];
      r   = {r[DEGREE-2:0], 1'b0};
      if (top) begin
        r = r ^ poly;
      end
      if (digit[j]) begin
        r = r ^ mcand;
      end
    end
    return r;
  endfunction

  assign a_m = operand_a_i[DEGREE-1:0];
  assign b_m = operand_b_i[DEGREE-1:0];

  always_comb begin
    res_d  = res_q;
    base_d = base_q;
    exp_d  = exp_q;
    acc0_d = acc0_q;
    acc1_d = acc1_q;
    sr0_d  = sr0_q;
    sr1_d  = sr1_q;
    if (cmd_i.load) begin
      base_d = a_m;
      case (kind_e'(kind_i))
        KIND_ADD: begin
          res_d = a_m ^ b_m;
          exp_d = '0;
        end
        KIND_MUL: begin
          res_d = b_m;
          exp_d = GF_EXP_W'(1);
        end
        KIND_POW: begin
          res_d = DEGREE'(1);
          exp_d = exponent_i;
        end
        default: begin
          res_d = '0;
          exp_d = '0;
        end
      endcase
    end
    if (cmd_i.round_start) begin
      acc0_d = '0;
      acc1_d = '0;
      sr0_d  = BW'(res_q);
      sr1_d  = BW'(base_q);
    end
    if (cmd_i.step) begin
      acc0_d = mul_step(acc0_q, base_q, sr0_q[BW-1 -: GF_DIGIT_W], poly_q);
      acc1_d = mul_step(acc1_q, base_q, sr1_q[BW-1 -: GF_DIGIT_W], poly_q);
      sr0_d  = sr0_q << GF_DIGIT_W;
      sr1_d  = sr1_q << GF_DIGIT_W;
    end
    if (cmd_i.update) begin
      base_d = acc1_q;
      if (exp_q[0]) begin
        res_d = acc0_q;
      end
      exp_d = exp_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= DEGREE'(3);
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i[DEGREE-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    acc0_q <= acc0_d;
    acc1_q <= acc1_d;
    sr0_q  <= sr0_d;
    sr1_q  <= sr1_d;
    if (cmd_i.out_load) begin
      value_q <= res_q;
    end
  end

  assign sts_o.exp_zero = (exp_q == '0);
  assign value_o        = GF_PORT_W'(value_q);

endmodule

`default_nettype wire

// ===== src/gf2m_ctrl.sv =====
// gf2m_ctrl: sequencer for load, multiply rounds and result hand-off
`default_nettype none

module gf2m_ctrl
  import gf2m_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam int unsigned CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIGITS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.exp_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.round_start = 1'b1;
          cnt_d             = CNT_LAST;
          state_d           = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_UPDATE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_CHECK;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  // multiply rounds only run with exponent bits left
  a_run_nonzero_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> !sts_i.exp_zero)
    else $error("round running with zero exponent");

  // last digit always leads to the update
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && cnt_q == '0) |=> (state_q == S_UPDATE))
    else $error("round did not end after last digit");

  // a new result only appears out of the finish state
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result valid without finish");

endmodule

`default_nettype wire

// ===== src/gf2m_arith_unit_core.sv =====
// gf2m_arith_unit_core: top level of the gf(2^DEGREE) add, multiply and power unit
//
// input channel: in_valid_i / in_stall_o carry kind_i, operand_a_i, operand_b_i and
// exponent_i; a transaction happens when valid is high and stall is low. output
// channel: out_valid_o / out_stall_i carry value_o, one result per input transaction.
// cfg_we_i writes cfg_wdata_i into the low-terms register of the reduction polynomial.
// one transaction is processed at a time. add and the unused kind skip the rounds and pass
// from the check step straight to the finish step. multiply takes one round, power one
// round per exponent bit up to the highest set bit; a round starts, then steps the two
// 8-bit digit-serial multipliers (square and multiply run side by side) through
// ceil(DEGREE/8) digits and ends with an update of result, base and exponent. the next
// transaction is accepted only after the result is loaded and the control is back in
// idle. reset clears the control and out_valid_o, loads the low terms with 3 and leaves
// the output value register unchanged. a stalled result holds in the output register;
// the next transaction is accepted meanwhile and waits in the finish step until
// it drains.
`default_nettype none

module gf2m_arith_unit_core
  import gf2m_pkg::*;
#(
  parameter int unsigned DEGREE = 63
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [GF_PORT_W-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [GF_PORT_W-1:0] operand_a_i,
  input  wire logic [GF_PORT_W-1:0] operand_b_i,
  input  wire logic [GF_EXP_W-1:0]  exponent_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [GF_PORT_W-1:0]      value_o
);

  localparam int unsigned NDIG = (DEGREE + GF_DIGIT_W - 1) / GF_DIGIT_W;

  cmd_t cmd;
  sts_t sts;

  gf2m_ctrl #(
    .NUM_DIGITS(NDIG)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gf2m_dp #(
    .DEGREE(DEGREE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .kind_i     (kind_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .exponent_i (exponent_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_o    (value_o)
  );

endmodule

`default_nettype wire
